@@ rtl/core/vt4_pkg.sv @@
`timescale 1ns / 1ps
// Shared widths, command codes and word types for the 4x4 vertex transform.
// No dependencies.
package vt4_pkg;

  localparam int unsigned DIM           = 4;
  localparam int unsigned IDX_W         = $clog2(DIM);
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned FRAC_BITS_DEF = 16;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_XFRM = 1'b1;

  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic [DIM*DATA_W-1:0]    col_word_t;

endpackage

@@ rtl/core/vertex_transform_4x4.sv @@
`timescale 1ns / 1ps
// Transform: each column passes the column read register, the product register and the
// pair-sum register; done_o rises with the output register of the last column. Columns are
// issued through the single read port of the column memory (one column of four coefficients per cycle).
// A load reads one column, merges the coefficient into it and writes the column back.
// Reset clears control and marks every column invalid, so the matrix reads as identity.
// Depends on vt4_pkg.
module vertex_transform_4x4
  import vt4_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic             command_i,
  input  logic [IDX_W-1:0] row_index_i,
  input  logic [IDX_W-1:0] col_index_i,
  input  word_t            coefficient_i,
  input  word_t            in_x_i,
  input  word_t            in_y_i,
  input  word_t            in_z_i,
  input  word_t            in_w_i,
  output word_t            out_x_o,
  output word_t            out_y_o,
  output word_t            out_z_o,
  output word_t            out_w_o,
  output logic             overflow_o,
  output logic             done_o
);

  localparam int unsigned PROD_W = 2 * DATA_W;
  localparam int unsigned PAIR_W = PROD_W + 1;
  localparam int unsigned SUM_W  = PROD_W + 2;
  localparam int unsigned SH_W   = SUM_W - FRAC_BITS;

  localparam logic [DATA_W-1:0] ONE_Q   = DATA_W'(1) << FRAC_BITS;
  localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_XFRM = 2'd1;
  localparam logic [1:0] ST_LOAD = 2'd2;

  function automatic col_word_t ident_col(input logic [IDX_W-1:0] c);
    col_word_t w;
    w = '0;
    for (int r = 0; r < DIM; r++) begin
      if (IDX_W'(r) == c) begin
        w[r*DATA_W +: DATA_W] = ONE_Q;
      end
    end
    return w;
  endfunction

  logic [1:0]        state_q, state_d;
  logic [IDX_W-1:0]  iss_q, iss_d;
  logic              accept, acc_x, acc_ld;
  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;
  logic              s1_v_d;

  word_t             vec_q [DIM];
  logic [IDX_W-1:0]  ld_row_q;
  word_t             ld_coef_q;

  col_word_t         mem_q [DIM];
  logic [DIM-1:0]    valid_q;
  col_word_t         rd_data_q;
  logic              rd_vld_q;
  logic [IDX_W-1:0]  rd_col_q;
  col_word_t         col_eff;
  col_word_t         wr_data;
  word_t             lane [DIM];

  logic                      s1_v_q;
  logic                      s2_v_q, s3_v_q;
  logic [IDX_W-1:0]          s2_col_q, s3_col_q;
  logic signed [PROD_W-1:0]  prod_q [DIM];
  logic signed [PAIR_W-1:0]  pair_q [2];
  logic signed [SUM_W-1:0]   sum;
  logic signed [SH_W-1:0]    sh;
  logic [SH_W-DATA_W:0]      sh_top;
  logic [DATA_W-1:0]         sat;
  logic                      sat_ovf;

  word_t             comp_q [DIM-1];
  logic              ovf_q;
  word_t             out_q [DIM];
  logic              ovf_out_q;
  logic              done_q;

  // Control
  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;
  assign acc_x  = accept && (command_i == CMD_XFRM);
  assign acc_ld = accept && (command_i == CMD_LOAD);

  always_comb begin
    state_d = state_q;
    iss_d   = iss_q;
    rd_addr = '0;
    wr_en   = 1'b0;
    s1_v_d  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        rd_addr = acc_ld ? col_index_i : '0;
        s1_v_d  = acc_x;
        if (acc_x) begin
          state_d = ST_XFRM;
          iss_d   = IDX_W'(1);
        end else if (acc_ld) begin
          state_d = ST_LOAD;
        end
      end
      ST_XFRM: begin
        rd_addr = iss_q;
        s1_v_d  = 1'b1;
        iss_d   = iss_q + IDX_W'(1);
        if (iss_q == IDX_W'(DIM-1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_LOAD: begin
        wr_en   = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      iss_q    <= '0;
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
      s1_v_q   <= 1'b0;
      s2_v_q   <= 1'b0;
      s3_v_q   <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      iss_q    <= iss_d;
      rd_vld_q <= valid_q[rd_addr];
      if (wr_en) begin
        valid_q[rd_col_q] <= 1'b1;
      end
      s1_v_q   <= s1_v_d;
      s2_v_q   <= s1_v_q;
      s3_v_q   <= s2_v_q;
      done_q   <= s3_v_q && (s3_col_q == IDX_W'(DIM-1));
    end
  end

  // Latch the command word
  always_ff @(posedge clk_i) begin
    if (acc_x) begin
      vec_q[0] <= in_x_i;
      vec_q[1] <= in_y_i;
      vec_q[2] <= in_z_i;
      vec_q[3] <= in_w_i;
    end
    if (acc_ld) begin
      ld_row_q  <= row_index_i;
      ld_coef_q <= coefficient_i;
    end
  end

  // Column memory: one column of the matrix per entry
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[rd_col_q] <= wr_data;
    end
    rd_data_q <= mem_q[rd_addr];
    rd_col_q  <= rd_addr;
  end

  always_comb begin
    col_eff = rd_vld_q ? rd_data_q : ident_col(rd_col_q);
    wr_data = col_eff;
    wr_data[ld_row_q*DATA_W +: DATA_W] = ld_coef_q;
    for (int r = 0; r < DIM; r++) begin
      lane[r] = col_eff[r*DATA_W +: DATA_W];
    end
  end

  // Multiply, pair, reduce
  always_ff @(posedge clk_i) begin
    for (int r = 0; r < DIM; r++) begin
      prod_q[r] <= PROD_W'(lane[r]) * PROD_W'(vec_q[r]);
    end
    s2_col_q  <= rd_col_q;
    pair_q[0] <= PAIR_W'(prod_q[0]) + PAIR_W'(prod_q[1]);
    pair_q[1] <= PAIR_W'(prod_q[2]) + PAIR_W'(prod_q[3]);
    s3_col_q  <= s2_col_q;
  end

  always_comb begin
    sum     = SUM_W'(pair_q[0]) + SUM_W'(pair_q[1]);
    sh      = $signed(sum[SUM_W-1:FRAC_BITS]);
    sh_top  = sh[SH_W-1:DATA_W-1];
    sat_ovf = !((&sh_top) || !(|sh_top));
    if (!sat_ovf) begin
      sat = sh[DATA_W-1:0];
    end else if (sh[SH_W-1]) begin
      sat = SAT_MIN;
    end else begin
      sat = SAT_MAX;
    end
  end

  // Collect components, publish on the last column
  always_ff @(posedge clk_i) begin
    if (s3_v_q) begin
      for (int k = 0; k < DIM-1; k++) begin
        if (s3_col_q == IDX_W'(k)) begin
          comp_q[k] <= sat;
        end
      end
      ovf_q <= (s3_col_q == '0) ? sat_ovf : (ovf_q | sat_ovf);
      if (s3_col_q == IDX_W'(DIM-1)) begin
        for (int k = 0; k < DIM-1; k++) begin
          out_q[k] <= comp_q[k];
        end
        out_q[DIM-1] <= sat;
        ovf_out_q    <= ovf_q | sat_ovf;
      end
    end
  end

  assign out_x_o    = out_q[0];
  assign out_y_o    = out_q[1];
  assign out_z_o    = out_q[2];
  assign out_w_o    = out_q[3];
  assign overflow_o = ovf_out_q;
  assign done_o     = done_q;

`ifndef SYNTHESIS
  a_xfrm_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (command_i == CMD_XFRM)) |-> ##7 done_o)
    else $error("transform word not delivered on time");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held longer than one cycle");

  a_done_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(s3_v_q && (s3_col_q == IDX_W'(DIM-1))))
    else $error("result strobe without a final column");

  a_load_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD) |-> !s1_v_q)
    else $error("write-back merges a transform column");
`endif

endmodule
